// ===== design/lzss_token_decoder_assert.svh =====
// assertion macros for the lzss token decoder checker
// no dependencies
`ifndef LZSS_TOKEN_DECODER_ASSERT_SVH
`define LZSS_TOKEN_DECODER_ASSERT_SVH
`define LZD_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lzd assertion failed");
`define LZD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lzd assertion failed");
`endif

// ===== design/lzd_pkg.sv =====
// shared types and constants for the lzss token decoder
// no dependencies
package lzd_pkg;
    localparam int unsigned DIST_W = 20;
    localparam int unsigned LEN_W = 8;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SIZE_W = 25;
    localparam int unsigned CNT_W = 4;
    localparam int unsigned NUM_LANES = 8;
    localparam int unsigned ADDR_BLOCK_SIZE = 0;

    typedef struct packed {
        logic                   match_flag;
        logic [DIST_W-1:0]      dist_code;
        logic [LEN_W-1:0]       len_code;
        logic [BYTE_W-1:0]      literal;
    } t_token;

    typedef struct packed {
        logic [NUM_LANES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]       byte_count;
        logic                   last_of_token;
        logic                   block_done;
        logic                   distance_error;
    } t_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_COPY,
        ST_OUT
    } t_state;
endpackage

// ===== design/lzd_if.sv =====
// valid/ready channel interface carrying one item
// no dependencies
interface lzd_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/lzss_token_decoder.sv =====
// lzss token decoder: tokens in, beats of decoded bytes out
// depends on lzd_pkg and lzd_if
// a literal or an ignored token gives its beat in the cycle after accept
// a match steps each byte through the single history port (read, wait, write)
// plus an output state per beat; one token at a time, a stalled beat holds the block
// synchronous active-low reset clears control and counters; history is not cleared
module lzss_token_decoder #(
    parameter int unsigned HISTORY_DEPTH = 32768,
    parameter int unsigned MIN_MATCH = 3,
    parameter int unsigned BYTES_PER_BEAT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzd_if.sink         i_tok,
    lzd_if.source       o_beat,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lzd_pkg::*;

    localparam int unsigned HA_W = $clog2(HISTORY_DEPTH);
    localparam int unsigned LANE_W = $clog2(NUM_LANES);

    logic [BYTE_W-1:0] r_mem [HISTORY_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    t_state r_state, n_state;
    logic [SIZE_W-1:0] r_block_size, r_written, r_len, r_done_cnt;
    logic [DIST_W:0]   r_dist;
    logic              r_derr;
    t_beat             r_beat;
    logic [CNT_W-1:0]  r_lane;
    logic              r_out_valid;

    logic cfg_wr, tok_acc, beat_acc, src_ok, wr_en;
    logic [SIZE_W-1:0] remain, len_full, src_pos;
    logic [BYTE_W-1:0] copy_byte;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'(ADDR_BLOCK_SIZE));
    assign prdata = (paddr == 2'(ADDR_BLOCK_SIZE)) ? 32'(r_block_size) : 32'd0;

    assign i_tok.ready = (r_state == ST_IDLE);
    assign tok_acc = i_tok.valid && i_tok.ready;
    assign o_beat.valid = r_out_valid;
    assign o_beat.data = r_beat;
    assign beat_acc = r_out_valid && o_beat.ready;

    assign remain = r_block_size - r_written;
    assign len_full = SIZE_W'(i_tok.data.len_code) + SIZE_W'(MIN_MATCH);
    assign src_pos = r_written - SIZE_W'(r_dist);
    assign src_ok = !r_derr && (r_written >= SIZE_W'(r_dist));
    assign copy_byte = src_ok ? r_rdata : '0;
    assign wr_en = (r_state == ST_COPY);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (tok_acc) begin
                if (r_written >= r_block_size || !i_tok.data.match_flag) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_WAIT;
            ST_WAIT: n_state = ST_COPY;
            ST_COPY: begin
                if (r_done_cnt + 1'b1 >= r_len ||
                    r_lane == CNT_W'(BYTES_PER_BEAT - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_OUT: if (beat_acc) begin
                n_state = r_beat.last_of_token ? ST_IDLE : ST_READ;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rdata <= r_mem[src_pos[HA_W-1:0]];
        end
        if (wr_en) begin
            r_mem[r_written[HA_W-1:0]] <= copy_byte;
        end else if (r_state == ST_IDLE && tok_acc && !i_tok.data.match_flag
                     && r_written < r_block_size) begin
            r_mem[r_written[HA_W-1:0]] <= i_tok.data.literal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_block_size <= '0;
            r_written <= '0;
            r_out_valid <= 1'b0;
            r_lane <= '0;
            r_done_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_block_size <= pwdata[SIZE_W-1:0];
                r_written <= '0;
            end
            unique case (r_state)
                ST_IDLE: if (tok_acc) begin
                    r_beat <= '0;
                    r_lane <= '0;
                    r_done_cnt <= '0;
                    r_dist <= (DIST_W+1)'(i_tok.data.dist_code) + 1'b1;
                    r_derr <= (DIST_W+1)'(i_tok.data.dist_code) + 1'b1
                              > (DIST_W+1)'(HISTORY_DEPTH);
                    r_len <= (len_full > remain) ? remain : len_full;
                    if (r_written >= r_block_size) begin
                        r_beat.last_of_token <= 1'b1;
                        r_beat.block_done <= 1'b1;
                        r_out_valid <= 1'b1;
                    end else if (!i_tok.data.match_flag) begin
                        r_beat.bytes[0] <= i_tok.data.literal;
                        r_beat.byte_count <= CNT_W'(1);
                        r_beat.last_of_token <= 1'b1;
                        r_beat.block_done <= (r_written + 1'b1 >= r_block_size);
                        r_written <= r_written + 1'b1;
                        r_out_valid <= 1'b1;
                    end
                end
                ST_COPY: begin
                    r_beat.bytes[r_lane[LANE_W-1:0]] <= copy_byte;
                    r_beat.byte_count <= r_lane + 1'b1;
                    r_beat.distance_error <= r_derr;
                    r_written <= r_written + 1'b1;
                    r_done_cnt <= r_done_cnt + 1'b1;
                    r_lane <= r_lane + 1'b1;
                    if (n_state == ST_OUT) begin
                        r_beat.last_of_token <= (r_done_cnt + 1'b1 >= r_len);
                        r_beat.block_done <= (r_written + 1'b1 >= r_block_size);
                        r_out_valid <= 1'b1;
                    end
                end
                ST_OUT: if (beat_acc) begin
                    r_out_valid <= 1'b0;
                    r_lane <= '0;
                    r_beat.bytes <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== design/lzd_checker.sv =====
// port-level assertions for the lzss token decoder, bound to the top level
// depends on lzss_token_decoder_assert.svh
`include "lzss_token_decoder_assert.svh"
module lzd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        tok_valid,
    input logic        tok_ready,
    input logic        beat_valid,
    input logic        beat_ready,
    input logic [3:0]  byte_count,
    input logic        last_of_token,
    input logic        distance_error
);
    `LZD_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, beat_valid, byte_count <= 4'd8)
    `LZD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, tok_valid && tok_ready,
        !tok_ready)
    `LZD_ASSERT_NEXT(a_beat_held, i_clk, i_rst_n, beat_valid && !beat_ready, beat_valid)
    `LZD_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n, beat_valid && byte_count == 4'd0,
        last_of_token)
    `LZD_ASSERT_IMPL(a_err_nonempty, i_clk, i_rst_n, beat_valid && distance_error,
        byte_count != 4'd0)
endmodule

bind lzss_token_decoder lzd_checker u_lzd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .tok_valid(i_tok.valid),
    .tok_ready(i_tok.ready),
    .beat_valid(o_beat.valid),
    .beat_ready(o_beat.ready),
    .byte_count(o_beat.data.byte_count),
    .last_of_token(o_beat.data.last_of_token),
    .distance_error(o_beat.data.distance_error)
);
